/* sv/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, codes and types for the fixed page pool allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Pool geometry
  localparam int POOL_PAGES = 17;
  localparam int PAGE_SHIFT = 13;
  localparam int PAGE_BYTES = 1 << PAGE_SHIFT;
  localparam int ADDR_W     = 32;
  localparam int IDX_W      = 5;
  localparam int CNT_W      = 5;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'h2000_0000;

  // Request codes (the spare code behaves as a report)
  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_MEM   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD_ADDR = 2'd2;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 56;

  // Lookup results from the page finder
  typedef struct packed {
    logic             alloc_hit;
    logic [IDX_W-1:0] alloc_idx;
    logic             free_hit;
    logic [IDX_W-1:0] free_idx;
  } find_t;

  // One result
  typedef struct packed {
    logic [IDX_W-1:0]  high_mark;
    logic [CNT_W-1:0]  used_pages;
    logic [CNT_W-1:0]  free_pages;
    logic [IDX_W-1:0]  page_number;
    logic [ADDR_W-1:0] granted_address;
    logic [STAT_W-1:0] status;
  } result_t;

endpackage

/* sv/fixed_page_pool_allocator_core.sv */
// ----------------------------------------------------------------------------
// fixed_page_pool_allocator_core
// Allocates and frees equal-size pages laid out from a programmable base.
//
//   Channel | Direction | tdata fields (low bit up)             | tuser
//   in_     | slave     | command, page_address                 | -
//   out_    | master    | status, granted_address, page_number, | -
//           |           | free_pages, used_pages, high_mark     |
//   cfg_    | write     | pool_base                             | -
//
// One request per cycle sustained while out_tready is high; a request reaches
// out_tvalid via the input and then the result register. Pool state updates
// as a request moves from the input register into the result register.
// Reset leaves every page free, high mark zero and base 0x2000_0000.
// A stall on out_tready holds the result register; in_tready drops once the
// input register also holds a request.
// ----------------------------------------------------------------------------
module fixed_page_pool_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // command[1:0], page_address[33:2], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // status[1:0], granted_address[33:2],
                                  // page_number[38:34], free_pages[43:39],
                                  // used_pages[48:44], high_mark[53:49], pad
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [fpa_pkg::ADDR_W-1:0]     pool_base_r;
  logic                           s1_valid_r;
  logic [fpa_pkg::CMD_W-1:0]      s1_cmd_r;
  logic [fpa_pkg::ADDR_W-1:0]     s1_addr_r;
  logic                           out_valid_r;
  fpa_pkg::result_t               out_res_r;
  logic                           advance;
  logic [fpa_pkg::POOL_PAGES-1:0] free_mask;
  fpa_pkg::find_t                 find;
  fpa_pkg::result_t               result;

  // Handshake: stage 1 moves on when the result register is empty or being read
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  // Base address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= fpa_pkg::POOL_BASE_RST;
    end else if (cfg_wr_en) begin
      pool_base_r <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= in_tdata[1:0];
      s1_addr_r <= in_tdata[33:2];
    end
  end

  fpa_page_find u_find (
    .free_mask    (free_mask),
    .pool_base    (pool_base_r),
    .page_address (s1_addr_r),
    .find         (find)
  );

  fpa_pool_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .command   (s1_cmd_r),
    .pool_base (pool_base_r),
    .find      (find),
    .free_mask (free_mask),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

endmodule

/* sv/fpa_page_find.sv */
// ----------------------------------------------------------------------------
// fpa_page_find
// Lowest free page search and page-aligned address match.
// ----------------------------------------------------------------------------
module fpa_page_find (
  input  logic [fpa_pkg::POOL_PAGES-1:0] free_mask,
  input  logic [fpa_pkg::ADDR_W-1:0]     pool_base,
  input  logic [fpa_pkg::ADDR_W-1:0]     page_address,
  output fpa_pkg::find_t                 find
);

  logic [fpa_pkg::ADDR_W-1:0] offset;

  // Offsets never wrap inside the pool, so at most one page can match
  assign offset = page_address - pool_base;

  always_comb begin
    // Priority encode: lowest set bit wins
    find.alloc_hit = |free_mask;
    find.alloc_idx = '0;
    for (int i = fpa_pkg::POOL_PAGES - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        find.alloc_idx = fpa_pkg::IDX_W'(i);
      end
    end
    // Page-aligned match against the pool span
    find.free_hit = (offset[fpa_pkg::PAGE_SHIFT-1:0] == '0) &&
                    (offset[fpa_pkg::ADDR_W-1:fpa_pkg::PAGE_SHIFT] <
                     (fpa_pkg::ADDR_W-fpa_pkg::PAGE_SHIFT)'(fpa_pkg::POOL_PAGES));
    find.free_idx = offset[fpa_pkg::PAGE_SHIFT+fpa_pkg::IDX_W-1:fpa_pkg::PAGE_SHIFT];
  end

endmodule

/* sv/fpa_pool_state.sv */
// ----------------------------------------------------------------------------
// fpa_pool_state
// Free mask and high-water registers, state update and result assembly.
// ----------------------------------------------------------------------------
module fpa_pool_state (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [fpa_pkg::CMD_W-1:0]  command,
  input  logic [fpa_pkg::ADDR_W-1:0] pool_base,
  input  fpa_pkg::find_t             find,
  output logic [fpa_pkg::POOL_PAGES-1:0] free_mask,
  output fpa_pkg::result_t           result
);

  logic [fpa_pkg::POOL_PAGES-1:0] free_mask_r, free_mask_nxt;
  logic [fpa_pkg::IDX_W-1:0]      high_r, high_nxt;
  logic [fpa_pkg::CNT_W-1:0]      nfree;
  logic [fpa_pkg::STAT_W-1:0]     res_status;
  logic [fpa_pkg::ADDR_W-1:0]     res_granted;
  logic [fpa_pkg::IDX_W-1:0]      res_page;

  assign free_mask = free_mask_r;

  // Request decode and next state
  always_comb begin
    free_mask_nxt = free_mask_r;
    high_nxt      = high_r;
    res_status    = fpa_pkg::ST_OK;
    res_granted   = '0;
    res_page      = '0;
    case (command)
      fpa_pkg::CMD_ALLOC: begin
        if (find.alloc_hit) begin
          free_mask_nxt[find.alloc_idx] = 1'b0;
          if (find.alloc_idx > high_r) begin
            high_nxt = find.alloc_idx;
          end
          res_granted = pool_base +
            {{(fpa_pkg::ADDR_W-fpa_pkg::IDX_W-fpa_pkg::PAGE_SHIFT){1'b0}},
             find.alloc_idx, {fpa_pkg::PAGE_SHIFT{1'b0}}};
          res_page = find.alloc_idx;
        end else begin
          res_status = fpa_pkg::ST_NO_MEM;
        end
      end
      fpa_pkg::CMD_FREE: begin
        if (find.free_hit) begin
          free_mask_nxt[find.free_idx] = 1'b1;
          res_page = find.free_idx;
        end else begin
          res_status = fpa_pkg::ST_BAD_ADDR;
        end
      end
      default: begin
      end
    endcase
  end

  // Free page count after this request
  always_comb begin
    nfree = '0;
    for (int i = 0; i < fpa_pkg::POOL_PAGES; i++) begin
      nfree = nfree + fpa_pkg::CNT_W'(free_mask_nxt[i]);
    end
  end

  // Result assembly
  always_comb begin
    result.status          = res_status;
    result.granted_address = res_granted;
    result.page_number     = res_page;
    result.free_pages      = nfree;
    result.used_pages      = fpa_pkg::CNT_W'(fpa_pkg::POOL_PAGES) - nfree;
    result.high_mark       = high_nxt;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_mask_r <= '1;
      high_r      <= '0;
    end else if (step) begin
      free_mask_r <= free_mask_nxt;
      high_r      <= high_nxt;
    end
  end

endmodule
